// File: rtl/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers. Both expect clk in scope; ASSERT_CHK also expects rst.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTH
// Checked only outside reset.
`define ASSERT_CHK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked during reset as well.
`define ASSERT_ALWAYS(label, prop, msg) \
  label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CHK(label, prop, msg)
`define ASSERT_ALWAYS(label, prop, msg)
`endif
`endif

// File: rtl/gcfb_pkg.sv
// ----------------------------------------------------------------------------
// gcfb_pkg
// Types and fixed constants of the glyph column framebuffer blitter.
// ----------------------------------------------------------------------------
package gcfb_pkg;

  localparam logic [1:0] REQ_SET_CURSOR = 2'd0;
  localparam logic [1:0] REQ_DRAW       = 2'd1;
  localparam logic [1:0] REQ_CLEAR      = 2'd2;
  localparam logic [1:0] REQ_READ       = 2'd3;

  localparam logic [6:0] COL_LIMIT   = 7'd75;
  localparam logic [5:0] ROW_LIMIT   = 6'd41;
  localparam logic [7:0] INVERT_MASK = 8'hFF;
  localparam logic [7:0] ROW_STEP    = 8'd8;

  typedef struct packed {
    logic [1:0] req_type;
    logic [6:0] pos_x;
    logic [5:0] pos_y;
    logic [2:0] read_bank;
    logic [7:0] column_bits;
    logic [6:0] glyph_width;
    logic       first_column;
    logic       invert;
  } req_t;

  // Byte-level work for one accepted request.
  typedef struct packed {
    logic [7:0] col;
    logic [4:0] bank;
    logic       hit0;
    logic       hit1;
    logic [7:0] bits0;
    logic [7:0] bits1;
    logic       clip;
  } plan_t;

endpackage

// File: rtl/gcfb_req_if.sv
// ----------------------------------------------------------------------------
// gcfb_req_if
// Request channel: valid/ready handshake with one request word.
// ----------------------------------------------------------------------------
interface gcfb_req_if;
  logic       valid;
  logic       ready;
  logic [1:0] req_type;
  logic [6:0] pos_x;
  logic [5:0] pos_y;
  logic [2:0] read_bank;
  logic [7:0] column_bits;
  logic [6:0] glyph_width;
  logic       first_column;
  logic       invert;

  modport source(output valid, req_type, pos_x, pos_y, read_bank, column_bits,
                 glyph_width, first_column, invert, input ready);
  modport sink(input valid, req_type, pos_x, pos_y, read_bank, column_bits,
               glyph_width, first_column, invert, output ready);
endinterface

// File: rtl/gcfb_rsp_if.sv
// ----------------------------------------------------------------------------
// gcfb_rsp_if
// Response channel: valid/ready handshake with one result word.
// ----------------------------------------------------------------------------
interface gcfb_rsp_if;
  logic       valid;
  logic       ready;
  logic [7:0] read_data;
  logic [7:0] cursor_col;
  logic [7:0] cursor_row;
  logic       clipped;

  modport source(output valid, read_data, cursor_col, cursor_row, clipped,
                 input ready);
  modport sink(input valid, read_data, cursor_col, cursor_row, clipped,
               output ready);
endinterface

// File: rtl/gcfb_ram.sv
// ----------------------------------------------------------------------------
// gcfb_ram
// Generic simple dual-port RAM, one write and one registered read port.
// ----------------------------------------------------------------------------
module gcfb_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 504
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// File: rtl/gcfb_cursor.sv
// ----------------------------------------------------------------------------
// gcfb_cursor
// Cursor registers, wrap and clamp logic, and per-request byte planning.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module gcfb_cursor #(
  parameter int COLUMNS = 84,
  parameter int BANKS   = 6
) (
  input  logic           clk,
  input  logic           rst,
  input  logic           accept,
  input  gcfb_pkg::req_t req_word,
  output gcfb_pkg::plan_t plan,
  output logic [7:0]     cursor_col,
  output logic [7:0]     cursor_row
);
  import gcfb_pkg::*;

  logic        wrap;
  logic [7:0]  col_w;
  logic [7:0]  row_w;
  logic [7:0]  pix;
  logic [15:0] spread;
  logic [2:0]  shift;
  logic [4:0]  bank;
  logic        col_ok;
  logic        need1;
  logic        hit0;
  logic        hit1;
  logic        rd_ok;
  plan_t       plan_next;

  // The glyph moves to the next text line when it would run past the edge.
  assign wrap  = req_word.first_column &&
                 ((9'(req_word.glyph_width) + 9'(cursor_col)) > 9'(COLUMNS));
  assign col_w = wrap ? 8'd0 : cursor_col;
  assign row_w = wrap ? cursor_row + ROW_STEP : cursor_row;

  assign pix    = req_word.invert ? (req_word.column_bits ^ INVERT_MASK)
                                  : req_word.column_bits;
  assign shift  = row_w[2:0];
  assign bank   = row_w[7:3];
  assign spread = {8'h00, pix} << shift;

  assign col_ok = col_w < 8'(COLUMNS);
  assign need1  = shift != 3'd0;
  assign hit0   = col_ok && ({1'b0, bank} < 6'(BANKS));
  assign hit1   = need1 && col_ok && (({1'b0, bank} + 6'd1) < 6'(BANKS));
  assign rd_ok  = ({1'b0, req_word.pos_x} < 8'(COLUMNS)) &&
                  (5'(req_word.read_bank) < 5'(BANKS));

  always_comb begin
    plan_next = '0;
    unique case (req_word.req_type)
      REQ_DRAW: begin
        plan_next.col   = col_w;
        plan_next.bank  = bank;
        plan_next.hit0  = hit0;
        plan_next.hit1  = hit1;
        plan_next.bits0 = spread[7:0];
        plan_next.bits1 = spread[15:8];
        plan_next.clip  = !hit0 || (need1 && !hit1);
      end
      REQ_READ: begin
        plan_next.col  = {1'b0, req_word.pos_x};
        plan_next.bank = {2'b00, req_word.read_bank};
        plan_next.hit0 = rd_ok;
      end
      REQ_SET_CURSOR, REQ_CLEAR: begin
        plan_next = '0;
      end
      default: begin
        plan_next = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cursor_col <= 8'd0;
      cursor_row <= 8'd0;
    end else if (accept) begin
      unique case (req_word.req_type)
        REQ_SET_CURSOR: begin
          cursor_col <= {1'b0, (req_word.pos_x > COL_LIMIT) ? COL_LIMIT
                                                             : req_word.pos_x};
          cursor_row <= {2'b00, (req_word.pos_y > ROW_LIMIT) ? ROW_LIMIT
                                                              : req_word.pos_y};
        end
        REQ_DRAW: begin
          cursor_col <= col_w + 8'd1;
          cursor_row <= row_w;
        end
        REQ_CLEAR, REQ_READ: begin
          cursor_col <= cursor_col;
        end
        default: begin
          cursor_col <= cursor_col;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      plan <= plan_next;
    end
  end

  `ASSERT_CHK(a_set_clamps_col, accept && (req_word.req_type == REQ_SET_CURSOR) |=> cursor_col <= 8'(COL_LIMIT), "set cursor left column above limit")
  `ASSERT_CHK(a_draw_advances, accept && (req_word.req_type == REQ_DRAW) && !wrap |=> cursor_col == $past(cursor_col) + 8'd1, "draw did not advance column")
  `ASSERT_CHK(a_hit1_needs_col, accept && (req_word.req_type == REQ_DRAW) |=> !plan.hit1 || plan.hit0 || plan.bank >= 5'(BANKS), "second byte planned without valid column")

endmodule

// File: rtl/glyph_column_framebuffer_blit.sv
// ----------------------------------------------------------------------------
// glyph_column_framebuffer_blit
// Page framebuffer of COLUMNS x BANKS bytes with a pixel cursor and glyph
// column blitting through read-modify-write of one synchronous RAM.
// ----------------------------------------------------------------------------
//
//  Channel  Role    Word
//  -------  ------  -----------------------------------------------------------
//  req      sink    req_type, pos_x, pos_y, read_bank, column_bits,
//                   glyph_width, first_column, invert
//  rsp      source  read_data, cursor_col, cursor_row, clipped
//
// Path per request: set cursor goes straight to S_DONE, read runs S_RD and
// S_RDD, draw S_RD, S_WR0 and S_WR1, clear S_CLR. The result register loads in
// S_DONE at the end of each path. The draw path comes from the RAM port: each
// of the two target bytes is read, then merged and written back.
// After reset a clearing pass writes zero to all COLUMNS*BANKS entries, one a
// cycle (504 at the default size); no request is taken meanwhile.
// One request is in flight at a time. A finished result sits in the output
// register while the next request is accepted; only the final load waits for
// the result register to be free.
//
`include "assert_macros.svh"

module glyph_column_framebuffer_blit #(
  parameter int COLUMNS = 84,
  parameter int BANKS   = 6
) (
  input logic      clk,
  input logic      rst,
  gcfb_req_if.sink  req,
  gcfb_rsp_if.source rsp
);
  import gcfb_pkg::*;

  localparam int DEPTH = COLUMNS * BANKS;
  localparam int AW    = $clog2(DEPTH);

  // Sequencer states.
  localparam logic [2:0] S_CLR  = 3'd0;
  localparam logic [2:0] S_IDLE = 3'd1;
  localparam logic [2:0] S_RD   = 3'd2;
  localparam logic [2:0] S_WR0  = 3'd3;
  localparam logic [2:0] S_WR1  = 3'd4;
  localparam logic [2:0] S_RDD  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  logic [2:0]    state;
  logic [2:0]    state_next;
  logic [1:0]    op;
  logic [AW-1:0] clr_cnt;
  logic          clr_reply;
  logic [7:0]    rd_byte;

  logic          out_valid;
  logic [7:0]    out_read_data;
  logic [7:0]    out_cursor_col;
  logic [7:0]    out_cursor_row;
  logic          out_clipped;

  logic          accept;
  logic          load_out;
  req_t          req_word;
  plan_t         plan;
  logic [7:0]    cursor_col;
  logic [7:0]    cursor_row;

  logic [AW-1:0] addr0;
  logic [AW-1:0] addr1;
  logic          ram_we;
  logic [AW-1:0] ram_waddr;
  logic [7:0]    ram_wdata;
  logic [AW-1:0] ram_raddr;
  logic [7:0]    ram_rdata;

  assign req_word.req_type     = req.req_type;
  assign req_word.pos_x        = req.pos_x;
  assign req_word.pos_y        = req.pos_y;
  assign req_word.read_bank    = req.read_bank;
  assign req_word.column_bits  = req.column_bits;
  assign req_word.glyph_width  = req.glyph_width;
  assign req_word.first_column = req.first_column;
  assign req_word.invert       = req.invert;

  assign req.ready = state == S_IDLE;
  assign accept    = req.valid && req.ready;
  assign load_out  = (state == S_DONE) && (!out_valid || rsp.ready);

  gcfb_cursor #(
    .COLUMNS(COLUMNS),
    .BANKS  (BANKS)
  ) u_cursor (
    .clk       (clk),
    .rst       (rst),
    .accept    (accept),
    .req_word  (req_word),
    .plan      (plan),
    .cursor_col(cursor_col),
    .cursor_row(cursor_row)
  );

  // Byte addresses of the planned target and the one in the bank below it.
  // The second address is only written when the planner found it in range.
  assign addr0 = AW'(int'(plan.bank) * COLUMNS + int'(plan.col));
  assign addr1 = AW'((int'(plan.bank) + 1) * COLUMNS + int'(plan.col));

  // RAM port steering. The read of the second byte overlaps the write-back of
  // the first; the two addresses always differ, so no forwarding is needed.
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = addr0;
    ram_wdata = ram_rdata | plan.bits0;
    ram_raddr = addr0;
    unique case (state)
      S_CLR: begin
        ram_we    = 1'b1;
        ram_waddr = clr_cnt;
        ram_wdata = 8'h00;
      end
      S_WR0: begin
        ram_we    = plan.hit0;
        ram_raddr = addr1;
      end
      S_WR1: begin
        ram_we    = plan.hit1;
        ram_waddr = addr1;
        ram_wdata = ram_rdata | plan.bits1;
        ram_raddr = addr1;
      end
      S_IDLE, S_RD, S_RDD, S_DONE: begin
        ram_we = 1'b0;
      end
      default: begin
        ram_we = 1'b0;
      end
    endcase
  end

  gcfb_ram #(
    .WIDTH(8),
    .DEPTH(DEPTH)
  ) u_store (
    .clk  (clk),
    .we   (ram_we),
    .waddr(ram_waddr),
    .wdata(ram_wdata),
    .raddr(ram_raddr),
    .rdata(ram_rdata)
  );

  always_comb begin
    state_next = state;
    unique case (state)
      S_CLR: begin
        if (clr_cnt == AW'(DEPTH - 1)) begin
          state_next = clr_reply ? S_DONE : S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (req.req_type)
            REQ_SET_CURSOR: state_next = S_DONE;
            REQ_DRAW:       state_next = S_RD;
            REQ_CLEAR:      state_next = S_CLR;
            REQ_READ:       state_next = S_RD;
            default:        state_next = S_DONE;
          endcase
        end
      end
      S_RD: begin
        state_next = (op == REQ_DRAW) ? S_WR0 : S_RDD;
      end
      S_WR0:  state_next = S_WR1;
      S_WR1:  state_next = S_DONE;
      S_RDD:  state_next = S_DONE;
      S_DONE: begin
        if (load_out) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_CLR;
      clr_cnt   <= '0;
      clr_reply <= 1'b0;
      op        <= REQ_SET_CURSOR;
    end else begin
      state <= state_next;
      if (accept) begin
        op        <= req.req_type;
        clr_reply <= 1'b1;
        clr_cnt   <= '0;
      end else if (state == S_CLR) begin
        clr_cnt <= clr_cnt + AW'(1);
      end
    end
  end

  // Off-store reads return zero.
  always_ff @(posedge clk) begin
    if (state == S_RDD) begin
      rd_byte <= plan.hit0 ? ram_rdata : 8'h00;
    end
  end

  // Result register. It holds until taken; a finished request waits in
  // S_DONE only while the previous word is still unclaimed.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (load_out) begin
      out_valid <= 1'b1;
    end else if (rsp.ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load_out) begin
      out_read_data  <= (op == REQ_READ) ? rd_byte : 8'h00;
      out_cursor_col <= cursor_col;
      out_cursor_row <= cursor_row;
      out_clipped    <= (op == REQ_DRAW) && plan.clip;
    end
  end

  assign rsp.valid      = out_valid;
  assign rsp.read_data  = out_read_data;
  assign rsp.cursor_col = out_cursor_col;
  assign rsp.cursor_row = out_cursor_row;
  assign rsp.clipped    = out_clipped;

  `ASSERT_CHK(a_no_write_when_quiet, (state == S_IDLE || state == S_DONE || state == S_RD) |-> !ram_we, "store written outside a write state")
  `ASSERT_CHK(a_accept_leaves_idle, accept |=> state != S_IDLE, "request accepted but sequencer stayed idle")
  `ASSERT_CHK(a_done_holds, (state == S_DONE) && out_valid && !rsp.ready |=> state == S_DONE && out_valid, "result dropped while output was stalled")
  `ASSERT_CHK(a_clear_ends, (state == S_CLR) && (clr_cnt == AW'(DEPTH - 1)) |=> state != S_CLR, "clearing pass ran past the last entry")

endmodule
